FILE: hdl/tlib_pkg.sv
// ----------------------------------------------------------------------------
// tlib_pkg
// Shared types and character codes for the terminal line input buffer.
// ----------------------------------------------------------------------------
`default_nettype none

package tlib_pkg;

    localparam int BYTE_W       = 8;
    localparam int READ_COUNT_W = 7;
    localparam int CFG_INDEX_W  = 1;

    // control characters are the letter masked down to its low five bits
    localparam logic [BYTE_W-1:0] CTRL_MASK  = 8'h1F;
    localparam logic [BYTE_W-1:0] CH_INTR    = 8'h63 & CTRL_MASK;
    localparam logic [BYTE_W-1:0] CH_SUSP    = 8'h7A & CTRL_MASK;
    localparam logic [BYTE_W-1:0] CH_ERASE   = 8'h08;
    localparam logic [BYTE_W-1:0] CH_NEWLINE = 8'h0A;

    localparam logic [READ_COUNT_W-1:0] MAX_READ = 7'd64;

    localparam logic [CFG_INDEX_W-1:0] REG_ECHO  = 1'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_CANON = 1'd1;

    localparam logic MODE_RX   = 1'b0;
    localparam logic MODE_READ = 1'b1;

    typedef enum logic [2:0] {
        EV_ECHO     = 3'd0,
        EV_INTR     = 3'd1,
        EV_SUSP     = 3'd2,
        EV_DATA     = 3'd3,
        EV_NOTREADY = 3'd4
    } t_event_kind;

    typedef enum logic [1:0] {
        S_IDLE,
        S_CHECK,
        S_FETCH,
        S_SEND
    } t_state;

endpackage

`default_nettype wire

FILE: hdl/tlib_line_ram.sv
// ----------------------------------------------------------------------------
// tlib_line_ram
// Simple dual-port line store: one write port, one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module tlib_line_ram
    import tlib_pkg::*;
#(
    parameter int DEPTH  = 256,
    parameter int ADDR_W = 8
) (
    input  wire logic              i_clk,
    input  wire logic              i_wr_en,
    input  wire logic [ADDR_W-1:0] i_wr_addr,
    input  wire logic [BYTE_W-1:0] i_wr_data,
    input  wire logic              i_rd_en,
    input  wire logic [ADDR_W-1:0] i_rd_addr,
    output logic      [BYTE_W-1:0] o_rd_data
);

    logic [BYTE_W-1:0] r_mem [DEPTH];
    logic [BYTE_W-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

`default_nettype wire

FILE: hdl/terminal_line_input_buffer.sv
// Received byte: its result (if any) is in the output register the next cycle.
// Read request: the newest byte is fetched for the newline check, then each drained byte
// takes a line store read (S_FETCH) and then an output register load (S_SEND).
// Reads stretch while the output side stalls; the line store has a single read port.
// Reset: read and write pointers and occupancy cleared, echo and canonical mode enabled,
// no result pending; store contents are not cleared.
// ----------------------------------------------------------------------------
// terminal_line_input_buffer
// Line discipline input buffer: control characters, erase, echo and ring store
// with count-limited reads.
// ----------------------------------------------------------------------------
`default_nettype none

module terminal_line_input_buffer
    import tlib_pkg::*;
#(
    parameter int BUFFER_DEPTH = 256
) (
    input  wire logic                    i_clk,
    input  wire logic                    i_rst_n,
    // input items
    input  wire logic                    i_in_valid,
    output logic                         o_in_ready,
    input  wire logic                    i_mode,
    input  wire logic [BYTE_W-1:0]       i_rx_byte,
    input  wire logic [READ_COUNT_W-1:0] i_read_count,
    // results
    output logic                         o_out_valid,
    input  wire logic                    i_out_ready,
    output logic [2:0]                   o_event_kind,
    output logic [BYTE_W-1:0]            o_out_byte,
    output logic                         o_last,
    // configuration writes
    input  wire logic                    i_cfg_valid,
    output logic                         o_cfg_ready,
    input  wire logic [CFG_INDEX_W-1:0]  i_cfg_index,
    input  wire logic                    i_cfg_data
);

    localparam int PTR_W = $clog2(BUFFER_DEPTH);
    localparam int CMP_W = (PTR_W > READ_COUNT_W) ? PTR_W : READ_COUNT_W;
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(BUFFER_DEPTH - 1);

    t_state                  r_state, n_state;
    logic [PTR_W-1:0]        r_rd_ptr, n_rd_ptr;
    logic [PTR_W-1:0]        r_wr_ptr, n_wr_ptr;
    logic [PTR_W-1:0]        r_occ, n_occ;
    logic [READ_COUNT_W-1:0] r_count, n_count;
    logic [READ_COUNT_W-1:0] r_remain, n_remain;
    logic                    r_echo, r_canon;

    logic                    r_out_valid, n_out_valid;
    t_event_kind             r_out_kind, n_out_kind;
    logic [BYTE_W-1:0]       r_out_byte, n_out_byte;
    logic                    r_out_last, n_out_last;

    logic                    wr_en, rd_en;
    logic [PTR_W-1:0]        wr_addr, rd_addr;
    logic [BYTE_W-1:0]       rd_data;

    logic                    out_free, in_fire, cfg_fire;
    logic                    is_empty, is_full, newline_ok;
    logic [PTR_W-1:0]        wr_ptr_inc, wr_ptr_dec, rd_ptr_inc;
    logic [READ_COUNT_W-1:0] count_sat;
    logic [CMP_W-1:0]        occ_ext, cnt_ext, drain_ext;
    logic [READ_COUNT_W-1:0] drain_len;

    assign out_free = !r_out_valid || i_out_ready;
    assign o_in_ready = (r_state == S_IDLE) && out_free;
    assign in_fire = i_in_valid && o_in_ready;
    assign o_cfg_ready = 1'b1;
    assign cfg_fire = i_cfg_valid && o_cfg_ready;

    assign wr_ptr_inc = (r_wr_ptr == PTR_LAST) ? '0 : r_wr_ptr + 1'b1;
    assign wr_ptr_dec = (r_wr_ptr == '0) ? PTR_LAST : r_wr_ptr - 1'b1;
    assign rd_ptr_inc = (r_rd_ptr == PTR_LAST) ? '0 : r_rd_ptr + 1'b1;

    assign is_empty = (r_occ == '0);
    assign is_full  = (r_occ == PTR_LAST);
    assign count_sat = (i_read_count > MAX_READ) ? MAX_READ : i_read_count;
    assign newline_ok = !r_canon || (rd_data == CH_NEWLINE);

    // drain length never exceeds the saturated count, so it fits the count width
    assign occ_ext   = CMP_W'(r_occ);
    assign cnt_ext   = CMP_W'(r_count);
    assign drain_ext = (cnt_ext < occ_ext) ? cnt_ext : occ_ext;
    assign drain_len = drain_ext[READ_COUNT_W-1:0];

    tlib_line_ram #(
        .DEPTH  (BUFFER_DEPTH),
        .ADDR_W (PTR_W)
    ) u_ram (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (i_rx_byte),
        .i_rd_en   (rd_en),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (in_fire && (i_mode == MODE_READ) && !is_empty && (count_sat != '0)) begin
                    n_state = S_CHECK;
                end
            end
            S_CHECK: begin
                if (!newline_ok) begin
                    if (out_free) begin
                        n_state = S_IDLE;
                    end
                end else begin
                    n_state = S_FETCH;
                end
            end
            S_FETCH: begin
                n_state = S_SEND;
            end
            S_SEND: begin
                if (out_free) begin
                    n_state = (r_remain == READ_COUNT_W'(1)) ? S_IDLE : S_FETCH;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // datapath actions
    always_comb begin
        n_rd_ptr    = r_rd_ptr;
        n_wr_ptr    = r_wr_ptr;
        n_occ       = r_occ;
        n_count     = r_count;
        n_remain    = r_remain;
        n_out_valid = r_out_valid && !i_out_ready;
        n_out_kind  = r_out_kind;
        n_out_byte  = r_out_byte;
        n_out_last  = r_out_last;
        wr_en       = 1'b0;
        wr_addr     = r_wr_ptr;
        rd_en       = 1'b0;
        rd_addr     = r_rd_ptr;

        unique case (r_state)
            S_IDLE: begin
                if (in_fire) begin
                    if (i_mode == MODE_RX) begin
                        case (i_rx_byte)
                            CH_INTR: begin
                                n_out_valid = 1'b1;
                                n_out_kind  = EV_INTR;
                                n_out_byte  = '0;
                                n_out_last  = 1'b1;
                            end
                            CH_SUSP: begin
                                n_out_valid = 1'b1;
                                n_out_kind  = EV_SUSP;
                                n_out_byte  = '0;
                                n_out_last  = 1'b1;
                            end
                            CH_ERASE: begin
                                if (!is_empty) begin
                                    n_wr_ptr = wr_ptr_dec;
                                    n_occ    = r_occ - 1'b1;
                                    if (r_echo) begin
                                        n_out_valid = 1'b1;
                                        n_out_kind  = EV_ECHO;
                                        n_out_byte  = i_rx_byte;
                                        n_out_last  = 1'b1;
                                    end
                                end
                            end
                            default: begin
                                if (!is_full) begin
                                    wr_en    = 1'b1;
                                    n_wr_ptr = wr_ptr_inc;
                                    n_occ    = r_occ + 1'b1;
                                    if (r_echo) begin
                                        n_out_valid = 1'b1;
                                        n_out_kind  = EV_ECHO;
                                        n_out_byte  = i_rx_byte;
                                        n_out_last  = 1'b1;
                                    end
                                end
                            end
                        endcase
                    end else begin
                        n_count = count_sat;
                        if (is_empty || (count_sat == '0)) begin
                            n_out_valid = 1'b1;
                            n_out_kind  = EV_NOTREADY;
                            n_out_byte  = '0;
                            n_out_last  = 1'b1;
                        end else begin
                            // fetch the newest byte for the newline check
                            rd_en   = 1'b1;
                            rd_addr = wr_ptr_dec;
                        end
                    end
                end
            end
            S_CHECK: begin
                if (!newline_ok) begin
                    if (out_free) begin
                        n_out_valid = 1'b1;
                        n_out_kind  = EV_NOTREADY;
                        n_out_byte  = '0;
                        n_out_last  = 1'b1;
                    end
                end else begin
                    n_remain = drain_len;
                end
            end
            S_FETCH: begin
                rd_en    = 1'b1;
                rd_addr  = r_rd_ptr;
                n_rd_ptr = rd_ptr_inc;
                n_occ    = r_occ - 1'b1;
            end
            S_SEND: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_out_kind  = EV_DATA;
                    n_out_byte  = rd_data;
                    n_out_last  = (r_remain == READ_COUNT_W'(1));
                    n_remain    = r_remain - 1'b1;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_rd_ptr    <= '0;
            r_wr_ptr    <= '0;
            r_occ       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_rd_ptr    <= n_rd_ptr;
            r_wr_ptr    <= n_wr_ptr;
            r_occ       <= n_occ;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_count    <= n_count;
        r_remain   <= n_remain;
        r_out_kind <= n_out_kind;
        r_out_byte <= n_out_byte;
        r_out_last <= n_out_last;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_echo  <= 1'b1;
            r_canon <= 1'b1;
        end else if (cfg_fire) begin
            case (i_cfg_index)
                REG_ECHO:  r_echo  <= i_cfg_data;
                REG_CANON: r_canon <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_event_kind = r_out_kind;
    assign o_out_byte   = r_out_byte;
    assign o_last       = r_out_last;

endmodule

`default_nettype wire

FILE: hdl/tlib_checker.sv
// ----------------------------------------------------------------------------
// tlib_checker
// Port-level checks for the terminal line input buffer, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module tlib_checker
    import tlib_pkg::*;
(
    input wire logic                    i_clk,
    input wire logic                    i_rst_n,
    input wire logic                    i_in_valid,
    input wire logic                    o_in_ready,
    input wire logic                    o_out_valid,
    input wire logic                    i_out_ready,
    input wire logic [2:0]              o_event_kind,
    input wire logic [BYTE_W-1:0]       o_out_byte,
    input wire logic                    o_last
);

    // a stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |=>
            (o_out_valid && $stable(o_out_byte) && $stable(o_event_kind) && $stable(o_last)))
        else $error("stalled result changed");

    // no input transfer while a read burst still has bytes to come
    a_burst_blocks_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_event_kind == EV_DATA) && !o_last) |-> !(i_in_valid && o_in_ready))
        else $error("input accepted in the middle of a read burst");

    // only read data can come in multi-result bursts
    a_single_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_event_kind != EV_DATA)) |-> o_last)
        else $error("single result without last");

    // signal and not-ready results carry no byte
    a_zero_byte: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && ((o_event_kind == EV_INTR) || (o_event_kind == EV_SUSP)
            || (o_event_kind == EV_NOTREADY))) |-> (o_out_byte == '0))
        else $error("non-zero byte on a result that carries none");

endmodule

bind terminal_line_input_buffer tlib_checker u_tlib_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_in_valid   (i_in_valid),
    .o_in_ready   (o_in_ready),
    .o_out_valid  (o_out_valid),
    .i_out_ready  (i_out_ready),
    .o_event_kind (o_event_kind),
    .o_out_byte   (o_out_byte),
    .o_last       (o_last)
);

`default_nettype wire
